// ----- design/utli_pkg.sv -----
// Shared constants, codes and types for the uniform table linear interpolator.
// Used by the top, load and query modules; depends on nothing.
package utli_pkg;

  // Table and number format.
  localparam int TABLE_DEPTH = 1024;
  localparam int FRAC_BITS   = 16;
  localparam int VAL_W       = 32;
  localparam int CNT_W       = 11;
  localparam int MIN_POINTS  = 2;

  // Derived widths.
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int IDX_W  = $clog2(TABLE_DEPTH + 1);
  localparam int PROD_W = 2 * VAL_W;
  localparam int INT_W  = PROD_W - 2 * FRAC_BITS;
  localparam int N_W    = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int CMP_W  = (INT_W > N_W) ? INT_W : N_W;
  localparam int WGT_W  = FRAC_BITS + 1;
  localparam int SUM_W  = VAL_W + 2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_START     = 2'd0,
    CFG_RANGE_END       = 2'd1,
    CFG_INVERSE_SPACING = 2'd2,
    CFG_POINT_COUNT     = 2'd3
  } cfg_reg_t;

  // Item commands.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Saturation limits and reset values.
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] RANGE_START_RST = '0;
  localparam logic signed [VAL_W-1:0] RANGE_END_RST   = VAL_W'(64'd1 << FRAC_BITS);
  localparam logic [VAL_W-1:0]        INV_SPACING_RST = VAL_W'(64'd1 << FRAC_BITS);
  localparam logic [CNT_W-1:0]        POINT_COUNT_RST = CNT_W'(MIN_POINTS);

  // Configuration as seen by the query pipeline.
  typedef struct packed {
    logic signed [VAL_W-1:0] range_start;
    logic signed [VAL_W-1:0] range_end;
    logic [VAL_W-1:0]        inverse_spacing;
    logic [CNT_W-1:0]        point_count;
  } cfg_t;

  // Running extrema of the loaded samples.
  typedef struct packed {
    logic signed [VAL_W-1:0] min_v;
    logic signed [VAL_W-1:0] max_v;
  } extrema_t;

  // Write request to the sample memory.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  data;
  } wr_req_t;

  // One result beat leaving the query pipeline.
  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
    extrema_t                ext;
  } result_t;

endpackage

// ----- design/uniform_table_linear_interp_top.sv -----
// Top level of the uniform table linear interpolator: configuration registers,
// output register with skid stage, and the load, query and memory blocks.
// Depends on utli_pkg, utli_ram, utli_load and utli_query.
//
//   Channel | Direction | Beat carries
//   in_     | slave     | tdata: sample_value, query_x; tuser: command, first_sample
//   out_    | master    | tdata: interp_value, sample_min, sample_max
//   cfg_    | slave     | cfg_index, cfg_data (one register write)
//
// One item is accepted per cycle while in_tready is high. A query passes through
// the five pipeline stages around the memory read before its result appears.
// A load writes the memory through two write registers and gives no beat.
// Reset is synchronous; the sample memory is not cleared.
// A stalled output fills the skid stage; only then does in_tready drop.
module uniform_table_linear_interp_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input beats.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [63:0]                        in_tdata,  // sample_value, query_x
  input  logic [1:0]                         in_tuser,  // command, first_sample
  // Result beats.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [95:0]                        out_tdata, // interp_value, sample_min, sample_max
  // Configuration writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [utli_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [utli_pkg::VAL_W-1:0]         cfg_data
);

  utli_pkg::cfg_t    cfg_r;
  utli_pkg::extrema_t ext;
  utli_pkg::wr_req_t  wr;
  utli_pkg::result_t  res;

  logic                          en;
  logic                          in_acc, load_acc, q_acc;
  logic                          rd_en;
  logic [utli_pkg::ADDR_W-1:0]   rd_addr_a, rd_addr_b;
  logic [utli_pkg::VAL_W-1:0]    rd_data_a, rd_data_b;

  logic                          out_valid_r, skid_valid_r;
  utli_pkg::result_t             out_r, skid_r;
  logic                          pop;

  // The pipeline moves whenever the skid stage is free.
  assign en        = !skid_valid_r;
  assign in_tready = en;
  assign in_acc    = in_tvalid && in_tready;
  assign load_acc  = in_acc && (in_tuser[0] == utli_pkg::CMD_LOAD);
  assign q_acc     = in_acc && (in_tuser[0] == utli_pkg::CMD_QUERY);

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_start     <= utli_pkg::RANGE_START_RST;
      cfg_r.range_end       <= utli_pkg::RANGE_END_RST;
      cfg_r.inverse_spacing <= utli_pkg::INV_SPACING_RST;
      cfg_r.point_count     <= utli_pkg::POINT_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (utli_pkg::cfg_reg_t'(cfg_index))
        utli_pkg::CFG_RANGE_START:     cfg_r.range_start     <= cfg_data;
        utli_pkg::CFG_RANGE_END:       cfg_r.range_end       <= cfg_data;
        utli_pkg::CFG_INVERSE_SPACING: cfg_r.inverse_spacing <= cfg_data;
        utli_pkg::CFG_POINT_COUNT:     cfg_r.point_count     <= cfg_data[utli_pkg::CNT_W-1:0];
      endcase
    end
  end

  utli_load u_load (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .load_acc (load_acc),
    .first    (in_tuser[1]),
    .sample   (in_tdata[31:0]),
    .ext      (ext),
    .wr       (wr)
  );

  utli_ram #(
    .DEPTH (utli_pkg::TABLE_DEPTH),
    .WIDTH (utli_pkg::VAL_W)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr.en),
    .wr_addr   (wr.addr),
    .wr_data   (wr.data),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  utli_query u_query (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .q_acc     (q_acc),
    .query_x   (in_tdata[63:32]),
    .cfg       (cfg_r),
    .ext       (ext),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .res       (res)
  );

  // Output register with a skid stage behind it.
  assign pop = out_valid_r && out_tready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (res.valid) begin
      if (!out_valid_r || pop) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.ext.max_v, out_r.ext.min_v, out_r.value};

endmodule

// ----- design/utli_ram.sv -----
// Generic synchronous RAM with one write port and two registered read ports.
// Holds the sample table; depends on nothing.
module utli_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read ports; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// ----- design/utli_load.sv -----
// Load path: sample index counter, running extrema and the delayed memory write.
// Depends on utli_pkg.
module utli_load (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              load_acc,
  input  logic                              first,
  input  logic signed [utli_pkg::VAL_W-1:0] sample,
  output utli_pkg::extrema_t                ext,
  output utli_pkg::wr_req_t                 wr
);

  logic [utli_pkg::IDX_W-1:0]        idx_r, idx_nxt, idx_base;
  logic signed [utli_pkg::VAL_W-1:0] min_r, min_nxt, min_base;
  logic signed [utli_pkg::VAL_W-1:0] max_r, max_nxt, max_base;
  logic                              room;
  utli_pkg::wr_req_t                 wr_new;
  utli_pkg::wr_req_t                 w1_r;
  utli_pkg::wr_req_t                 w2_r;

  // A restart takes effect before the check for a full table.
  always_comb begin
    idx_base = first ? '0 : idx_r;
    min_base = first ? utli_pkg::VAL_MAX : min_r;
    max_base = first ? utli_pkg::VAL_MIN : max_r;
    room     = idx_base < utli_pkg::IDX_W'(utli_pkg::TABLE_DEPTH);

    wr_new.en   = load_acc && room;
    wr_new.addr = idx_base[utli_pkg::ADDR_W-1:0];
    wr_new.data = sample;

    idx_nxt = idx_r;
    min_nxt = min_r;
    max_nxt = max_r;
    if (load_acc) begin
      idx_nxt = room ? idx_base + 1'b1 : idx_base;
      min_nxt = (room && (sample < min_base)) ? sample : min_base;
      max_nxt = (room && (sample > max_base)) ? sample : max_base;
    end
  end

  // Counter and extrema registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      min_r <= utli_pkg::VAL_MAX;
      max_r <= utli_pkg::VAL_MIN;
    end else begin
      idx_r <= idx_nxt;
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  // The write travels two stages so that it reaches the memory at the same
  // pipeline position as a query read, keeping reads and writes in order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_r.en <= 1'b0;
      w2_r.en <= 1'b0;
    end else if (en) begin
      w1_r <= wr_new;
      w2_r <= w1_r;
    end
  end

  assign ext.min_v = min_r;
  assign ext.max_v = max_r;
  assign wr.en     = w2_r.en && en;
  assign wr.addr   = w2_r.addr;
  assign wr.data   = w2_r.data;

endmodule

// ----- design/utli_query.sv -----
// Query pipeline: clamp, scale, table read, weighting and saturating sum.
// Depends on utli_pkg; reads the sample memory through its two read ports.
module utli_query (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              q_acc,
  input  logic signed [utli_pkg::VAL_W-1:0] query_x,
  input  utli_pkg::cfg_t                    cfg,
  input  utli_pkg::extrema_t                ext,
  input  logic [utli_pkg::VAL_W-1:0]        rd_data_a,
  input  logic [utli_pkg::VAL_W-1:0]        rd_data_b,
  output logic                              rd_en,
  output logic [utli_pkg::ADDR_W-1:0]       rd_addr_a,
  output logic [utli_pkg::ADDR_W-1:0]       rd_addr_b,
  output utli_pkg::result_t                 res
);

  localparam int F = utli_pkg::FRAC_BITS;
  localparam int V = utli_pkg::VAL_W;

  // Stage valids.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  // Stage 1: clamped offset.
  logic              c_above, c_below, c_inv;
  logic [V-1:0]      dx, dh, d1;
  logic [V-1:0]      d1_r;
  utli_pkg::extrema_t ext1_r;

  // Stage 2: scaled offset.
  logic [utli_pkg::PROD_W-1:0] p2_r;
  utli_pkg::extrema_t          ext2_r;

  // Stage 3: read issued.
  logic [utli_pkg::INT_W-1:0] int_part;
  logic [F-1:0]               frac;
  logic [utli_pkg::N_W-1:0]   n_raw, n_sat, n_last;
  logic [utli_pkg::CMP_W-1:0] i_ext, n_last_ext;
  logic                       last3;
  logic [F-1:0]               f3_r;
  logic                       last3_r;
  utli_pkg::extrema_t         ext3_r;

  // Stage 4: magnitudes and signs of the sample pair.
  logic signed [V-1:0] ya, yb;
  logic [V-1:0]        ma4_r, mb4_r, ya4_r;
  logic                sa4_r, sb4_r, last4_r;
  logic [F-1:0]        f4_r;
  utli_pkg::extrema_t  ext4_r;

  // Stage 5: weighted magnitudes.
  logic [utli_pkg::WGT_W-1:0]   w_a, w_b;
  logic [utli_pkg::WGT_W+V-1:0] prod_a, prod_b;
  logic [V-1:0]                 ra5_r, rb5_r, ya5_r;
  logic                         sa5_r, sb5_r, last5_r;
  utli_pkg::extrema_t           ext5_r;

  // Final sum.
  logic [utli_pkg::SUM_W-1:0] ta, tb, sum;
  logic signed [V-1:0]        sat;

  // Clamp to range_end then range_start; all compares run side by side.
  always_comb begin
    c_above = query_x > cfg.range_end;
    c_below = query_x < cfg.range_start;
    c_inv   = cfg.range_end < cfg.range_start;
    dx      = query_x - cfg.range_start;
    dh      = cfg.range_end - cfg.range_start;
    if (c_above) begin
      d1 = c_inv ? '0 : dh;
    end else begin
      d1 = c_below ? '0 : dx;
    end
  end

  // Split the scaled offset, saturate the point count and pick the pair.
  always_comb begin
    int_part   = p2_r[utli_pkg::PROD_W-1 -: utli_pkg::INT_W];
    frac       = p2_r[2*F-1 -: F];
    n_raw      = utli_pkg::N_W'(cfg.point_count);
    if (n_raw < utli_pkg::N_W'(utli_pkg::MIN_POINTS)) begin
      n_sat = utli_pkg::N_W'(utli_pkg::MIN_POINTS);
    end else if (n_raw > utli_pkg::N_W'(utli_pkg::TABLE_DEPTH)) begin
      n_sat = utli_pkg::N_W'(utli_pkg::TABLE_DEPTH);
    end else begin
      n_sat = n_raw;
    end
    n_last     = n_sat - 1'b1;
    i_ext      = utli_pkg::CMP_W'(int_part);
    n_last_ext = utli_pkg::CMP_W'(n_last);
    last3      = i_ext >= n_last_ext;
    rd_addr_a  = last3 ? n_last_ext[utli_pkg::ADDR_W-1:0] : i_ext[utli_pkg::ADDR_W-1:0];
    rd_addr_b  = i_ext[utli_pkg::ADDR_W-1:0] + 1'b1;
  end

  assign rd_en = en && v2_r;

  // Signed views of the sample pair; their magnitudes feed the unsigned weighting.
  always_comb begin
    ya = rd_data_a;
    yb = rd_data_b;
  end

  // Weights sum to one; each product is truncated toward zero.
  always_comb begin
    w_b    = {1'b0, f4_r};
    w_a    = {1'b1, {F{1'b0}}} - {1'b0, f4_r};
    prod_a = (utli_pkg::WGT_W+V)'(w_a) * (utli_pkg::WGT_W+V)'(ma4_r);
    prod_b = (utli_pkg::WGT_W+V)'(w_b) * (utli_pkg::WGT_W+V)'(mb4_r);
  end

  // Signed sum of the two weighted samples, saturated to the value width.
  always_comb begin
    ta  = sa5_r ? ~{2'b00, ra5_r} : {2'b00, ra5_r};
    tb  = sb5_r ? ~{2'b00, rb5_r} : {2'b00, rb5_r};
    sum = ta + tb + utli_pkg::SUM_W'(sa5_r) + utli_pkg::SUM_W'(sb5_r);
    if (!sum[utli_pkg::SUM_W-1] && (|sum[utli_pkg::SUM_W-2:V-1])) begin
      sat = utli_pkg::VAL_MAX;
    end else if (sum[utli_pkg::SUM_W-1] && !(&sum[utli_pkg::SUM_W-2:V-1])) begin
      sat = utli_pkg::VAL_MIN;
    end else begin
      sat = sum[V-1:0];
    end
  end

  // Stage valids advance together with the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= q_acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Stage payloads; the extrema seen at acceptance ride along.
  always_ff @(posedge clk) begin
    if (en) begin
      d1_r    <= d1;
      ext1_r  <= ext;

      p2_r    <= utli_pkg::PROD_W'(d1_r) * utli_pkg::PROD_W'(cfg.inverse_spacing);
      ext2_r  <= ext1_r;

      f3_r    <= frac;
      last3_r <= last3;
      ext3_r  <= ext2_r;

      ma4_r   <= ya[V-1] ? V'(-ya) : V'(ya);
      mb4_r   <= yb[V-1] ? V'(-yb) : V'(yb);
      sa4_r   <= ya[V-1];
      sb4_r   <= yb[V-1];
      ya4_r   <= rd_data_a;
      f4_r    <= f3_r;
      last4_r <= last3_r;
      ext4_r  <= ext3_r;

      ra5_r   <= prod_a[F+V-1:F];
      rb5_r   <= prod_b[F+V-1:F];
      sa5_r   <= sa4_r;
      sb5_r   <= sb4_r;
      ya5_r   <= ya4_r;
      last5_r <= last4_r;
      ext5_r  <= ext4_r;
    end
  end

  // Past the last point the last sample is returned unchanged.
  assign res.valid = v5_r;
  assign res.value = last5_r ? ya5_r : sat;
  assign res.ext   = ext5_r;

endmodule

// ----- design/utli_checker.sv -----
// Port-level checks on the interpolator's handshakes and stall behaviour,
// bound to uniform_table_linear_interp_top; depends on nothing else.
module utli_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata
);

  // A stalled result beat stays and keeps its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Reset empties the output side and reopens the input.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("output not cleared by reset");

  // The input only closes while a result is waiting.
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input closed with no result waiting");

  // The input closes only after a stalled result.
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("input closed without an output stall");

endmodule

bind uniform_table_linear_interp_top utli_checker u_utli_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
